### rtl/mspid_pkg.sv
// Shared types and constants for the motor speed PID controller.
// Depends on nothing; imported by the controller top level.
package mspid_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
	localparam logic [2:0] REG_WHEEL_RADIUS  = 3'd3;
	localparam logic [2:0] REG_PWM_SCALE     = 3'd4;

	// Opcodes.
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_DISABLE = 1'b1;

	// Register reset values.
	localparam logic [15:0] RADIUS_RESET    = 16'd6554;
	localparam logic [11:0] PWM_SCALE_RESET = 12'd170;

	// Fixed-point thresholds. Speed is Q3.12, integral is Q16.16.
	localparam int SPEED_LIMIT    = 8192;     // 2.0 m/s
	localparam int INTEGRAL_LIMIT = 1572864;  // 24.0
	localparam int STILL_LIMIT    = 4;        // |speed| below 0.001 m/s
	localparam int NEAR_ZERO      = 40;       // |value| below 0.01 m/s
	localparam int MS_PER_SEC     = 1000;
	localparam int DUTY_MAX       = 255;
	localparam int DIV_STEPS      = 32;

	// ceil(2^40 / 1000): exact floor division by 1000 for dividends below 2^30.
	localparam logic [30:0] RECIP_MS = 31'd1099511628;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SPD,
		S_SPD_W,
		S_IMUL,
		S_IDIV_LD,
		S_IRCP_HI,
		S_IRCP_LO,
		S_IRCP_ACC,
		S_IDIV_END,
		S_DMUL,
		S_DDIV_LD,
		S_DDIV,
		S_DDIV_END,
		S_MKP,
		S_MKI,
		S_MKD,
		S_SUM,
		S_VOLT,
		S_DUTY,
		S_FIN
	} state_t;

endpackage

### rtl/motor_speed_pid_with_reversal.sv
// Speed PID controller with guarded direction reversal: one shared multiplier,
// which also divides by 1000 through a reciprocal, and one radix-2 divider
// sequenced by a small state machine. Depends on mspid_pkg.
//
// Sequencing: a control tick with nonzero elapsed time runs the integral step
// and the 32-step derivative division; with zero elapsed time it skips both,
// and a disable goes straight to the final step. The block is ready again on the
// cycle after the result is registered, so it takes no new item before the last
// is through; the last step also waits while the previous result is not taken.
// Reset (arst_n low) loads register defaults and clears all controller state.
module motor_speed_pid_with_reversal
	import mspid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [9:0]         elapsed_ms,
	input  logic signed [15:0] wheel_rate,
	input  logic signed [15:0] target_speed,
	input  logic               latch_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         pwm_duty,
	output logic               reverse_dir,
	output logic signed [15:0] drive_volts,
	output logic signed [15:0] measured_speed
);

	state_t state_q, state_d;

	// Configuration.
	logic [15:0] kp_q, ki_q, kd_q, radius_q;
	logic [11:0] pwm_scale_q;

	// Controller state.
	logic signed [15:0] prev_speed_q;
	logic signed [31:0] error_integral_q;
	logic signed [16:0] prev_error_q;
	logic               dir_backward_q;
	logic               committed_neg_q;

	// Captured item and working registers.
	logic               opc_q;
	logic [9:0]         elapsed_q;
	logic signed [15:0] rate_q, target_q;
	logic               latch_q;
	logic signed [15:0] speed_q;
	logic signed [16:0] err_q;
	logic signed [31:0] integ_q;
	logic signed [28:0] deriv_q;
	logic signed [51:0] acc_q;
	logic signed [15:0] volts_q;
	logic signed [49:0] prod_q;

	// Divider.
	logic [9:0]  div_rem_q, div_dvsr_q;
	logic [31:0] div_quo_q;
	logic        div_neg_q;
	logic [4:0]  div_cnt_q;
	logic [29:0] rnum_q;

	// Output register.
	logic               out_valid_q;
	logic [7:0]         pwm_duty_q;
	logic               reverse_dir_q;
	logic signed [15:0] drive_volts_q, measured_speed_q;

	// Shared multiplier operands.
	logic signed [16:0] mul_a;
	logic signed [32:0] mul_b;

	logic in_acc, out_free;
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Speed from the wheel rate, with the plausibility check.
	logic signed [37:0] speed_raw;
	logic               speed_ok;
	logic signed [15:0] speed_sel;
	logic signed [16:0] err_w;
	assign speed_raw = prod_q[49:12];
	assign speed_ok  = (speed_raw <= 38'(SPEED_LIMIT)) && (speed_raw >= -38'(SPEED_LIMIT));
	assign speed_sel = speed_ok ? speed_raw[15:0] : prev_speed_q;
	assign err_w     = {target_q[15], target_q} - {speed_sel[15], speed_sel};

	// Magnitudes used by the thresholds.
	logic [15:0]        speed_mag;
	logic signed [16:0] tgt_ext, volts_ext;
	logic [16:0]        tgt_mag, volts_mag;
	logic signed [32:0] eint_ext;
	logic [32:0]        eint_mag;
	logic signed [17:0] err_diff;
	assign speed_mag = speed_q[15] ? 16'(-speed_q) : speed_q;
	assign tgt_ext   = {target_q[15], target_q};
	assign tgt_mag   = tgt_ext[16] ? 17'(-tgt_ext) : tgt_ext;
	assign volts_ext = {volts_q[15], volts_q};
	assign volts_mag = volts_ext[16] ? 17'(-volts_ext) : volts_ext;
	assign eint_ext  = {error_integral_q[31], error_integral_q};
	assign eint_mag  = eint_ext[32] ? 33'(-eint_ext) : eint_ext;
	assign err_diff  = {err_q[16], err_q} - {prev_error_q[16], prev_error_q};

	logic integ_gate, integ_clear, near_still;
	assign integ_gate  = eint_mag <= 33'(INTEGRAL_LIMIT);
	assign integ_clear = (speed_mag <= 16'(STILL_LIMIT)) || (tgt_mag <= 17'(NEAR_ZERO));
	assign near_still  = speed_mag <= 16'(NEAR_ZERO);

	// Divider step: shift one dividend bit into the remainder and try a subtract.
	logic [11:0]        div_trial;
	logic               div_ge;
	logic [49:0]        prod_mag;
	logic signed [32:0] div_qmag, div_q;
	assign div_trial = {1'b0, div_rem_q, div_quo_q[31]} - {2'b00, div_dvsr_q};
	assign div_ge    = !div_trial[11];
	assign prod_mag  = prod_q[49] ? 50'(-prod_q) : prod_q;
	assign div_qmag  = {1'b0, div_quo_q};
	// Floor division: a negative dividend with a remainder rounds one further down.
	assign div_q = div_neg_q ? (-div_qmag - 33'(div_rem_q != 10'd0)) : div_qmag;

	// Integral step divided by 1000: the accumulated reciprocal product shifted
	// down by 40. A negative dividend was biased by 999 so that it rounds down.
	logic [21:0]        rcp_mag;
	logic signed [31:0] rcp_quo;
	assign rcp_mag = acc_q[46:25];
	assign rcp_quo = div_neg_q ? -$signed({10'd0, rcp_mag}) : $signed({10'd0, rcp_mag});

	// Volts and duty.
	logic signed [35:0] acc_sh;
	logic signed [15:0] volts_sat;
	logic [7:0]         duty_w;
	assign acc_sh = acc_q[51:16];
	always_comb begin
		if (acc_sh > 36'sd32767) begin
			volts_sat = 16'sh7FFF;
		end else if (acc_sh < -36'sd32768) begin
			volts_sat = 16'sh8000;
		end else begin
			volts_sat = acc_sh[15:0];
		end
	end
	assign duty_w = (prod_q[49:20] != 30'd0) ? 8'(DUTY_MAX) : prod_q[19:12];

	// Sign change handling.
	logic volts_neg, volts_pos, flip, new_dir, dir_next, cn_next;
	assign volts_neg = volts_q[15];
	assign volts_pos = !volts_q[15] && (volts_q != 16'sd0);
	assign flip      = (volts_neg && !committed_neg_q) || (volts_pos && committed_neg_q);
	assign new_dir   = volts_neg;
	always_comb begin
		dir_next = dir_backward_q;
		cn_next  = committed_neg_q;
		if (flip && near_still) begin
			dir_next = new_dir;
			if (latch_q == new_dir) begin
				cn_next = new_dir;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (opcode == OP_DISABLE) ? S_FIN : S_SPD;
				end
			end
			S_SPD:      state_d = S_SPD_W;
			S_SPD_W:    state_d = (elapsed_q == 10'd0) ? S_MKP : S_IMUL;
			S_IMUL:     state_d = S_IDIV_LD;
			S_IDIV_LD:  state_d = S_IRCP_HI;
			S_IRCP_HI:  state_d = S_IRCP_LO;
			S_IRCP_LO:  state_d = S_IRCP_ACC;
			S_IRCP_ACC: state_d = S_IDIV_END;
			S_IDIV_END: state_d = S_DMUL;
			S_DMUL:     state_d = S_DDIV_LD;
			S_DDIV_LD:  state_d = S_DDIV;
			S_DDIV:     state_d = (div_cnt_q == 5'(DIV_STEPS - 1)) ? S_DDIV_END : S_DDIV;
			S_DDIV_END: state_d = S_MKP;
			S_MKP:      state_d = S_MKI;
			S_MKI:      state_d = S_MKD;
			S_MKD:      state_d = S_SUM;
			S_SUM:      state_d = S_VOLT;
			S_VOLT:     state_d = S_DUTY;
			S_DUTY:     state_d = S_FIN;
			S_FIN:      state_d = out_free ? S_IDLE : S_FIN;
			default:    state_d = S_IDLE;
		endcase
	end

	// State outputs: handshake and multiplier operand selection.
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_SPD: begin
				mul_a = {1'b0, radius_q};
				mul_b = {{17{rate_q[15]}}, rate_q};
			end
			S_IMUL: begin
				mul_a = {7'd0, elapsed_q};
				mul_b = {{12{err_q[16]}}, err_q, 4'd0};
			end
			S_IRCP_HI: begin
				mul_a = {2'b00, rnum_q[29:15]};
				mul_b = {2'b00, RECIP_MS};
			end
			S_IRCP_LO: begin
				mul_a = {2'b00, rnum_q[14:0]};
				mul_b = {2'b00, RECIP_MS};
			end
			S_DMUL: begin
				mul_a = 17'(MS_PER_SEC);
				mul_b = {{15{err_diff[17]}}, err_diff};
			end
			S_MKP: begin
				mul_a = {1'b0, kp_q};
				mul_b = {{12{err_q[16]}}, err_q, 4'd0};
			end
			S_MKI: begin
				mul_a = {1'b0, ki_q};
				mul_b = {integ_q[31], integ_q};
			end
			S_MKD: begin
				mul_a = {1'b0, kd_q};
				mul_b = {deriv_q, 4'd0};
			end
			// The duty product is held while the result waits for the output register.
			S_DUTY, S_FIN: begin
				mul_a = {5'd0, pwm_scale_q};
				mul_b = {16'd0, volts_mag};
			end
			default: begin
			end
		endcase
	end

	// Control, configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			out_valid_q      <= 1'b0;
			kp_q             <= '0;
			ki_q             <= '0;
			kd_q             <= '0;
			radius_q         <= RADIUS_RESET;
			pwm_scale_q      <= PWM_SCALE_RESET;
			prev_speed_q     <= '0;
			error_integral_q <= '0;
			prev_error_q     <= '0;
			dir_backward_q   <= 1'b0;
			committed_neg_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_PROP_GAIN:     kp_q        <= cfg_wdata;
					REG_INTEGRAL_GAIN: ki_q        <= cfg_wdata;
					REG_DERIV_GAIN:    kd_q        <= cfg_wdata;
					REG_WHEEL_RADIUS:  radius_q    <= cfg_wdata;
					REG_PWM_SCALE:     pwm_scale_q <= cfg_wdata[11:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_FIN && out_free) begin
				if (opc_q == OP_DISABLE) begin
					prev_speed_q     <= '0;
					error_integral_q <= '0;
					prev_error_q     <= '0;
					dir_backward_q   <= 1'b0;
					committed_neg_q  <= 1'b0;
				end else begin
					prev_speed_q     <= speed_q;
					error_integral_q <= integ_q;
					prev_error_q     <= err_q;
					dir_backward_q   <= dir_next;
					committed_neg_q  <= cn_next;
				end
			end
		end
	end

	// Datapath and output payload.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc) begin
			opc_q     <= opcode;
			elapsed_q <= elapsed_ms;
			rate_q    <= wheel_rate;
			target_q  <= target_speed;
			latch_q   <= latch_level;
		end
		case (state_q)
			S_SPD_W: begin
				speed_q <= speed_sel;
				err_q   <= err_w;
				integ_q <= error_integral_q;
				deriv_q <= '0;
			end
			S_IDIV_LD: begin
				div_neg_q <= prod_q[49];
				rnum_q    <= prod_mag[29:0] + (prod_q[49] ? 30'(MS_PER_SEC - 1) : 30'd0);
			end
			S_IRCP_LO: acc_q <= {{2{prod_q[49]}}, prod_q};
			S_IRCP_ACC: acc_q <= acc_q + {17'd0, prod_q[49:15]};
			S_DDIV_LD: begin
				div_neg_q  <= prod_q[49];
				div_quo_q  <= prod_mag[31:0];
				div_rem_q  <= '0;
				div_dvsr_q <= elapsed_q;
				div_cnt_q  <= '0;
			end
			S_DDIV: begin
				div_rem_q <= div_ge ? div_trial[9:0] : {div_rem_q[8:0], div_quo_q[31]};
				div_quo_q <= {div_quo_q[30:0], div_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			S_IDIV_END: begin
				if (integ_gate) begin
					integ_q <= error_integral_q + rcp_quo;
				end
			end
			S_DDIV_END: deriv_q <= div_q[28:0];
			S_MKP: begin
				if (integ_clear) begin
					integ_q <= '0;
				end
			end
			S_MKI: acc_q <= {{2{prod_q[49]}}, prod_q};
			S_MKD, S_SUM: acc_q <= acc_q + {{2{prod_q[49]}}, prod_q};
			S_VOLT: volts_q <= volts_sat;
			S_FIN: begin
				if (out_free) begin
					if (opc_q == OP_DISABLE) begin
						pwm_duty_q       <= '0;
						reverse_dir_q    <= 1'b0;
						drive_volts_q    <= '0;
						measured_speed_q <= '0;
					end else begin
						// A pending reversal holds the duty at zero.
						pwm_duty_q       <= flip ? 8'd0 : duty_w;
						reverse_dir_q    <= dir_next;
						drive_volts_q    <= volts_q;
						measured_speed_q <= speed_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign pwm_duty       = pwm_duty_q;
	assign reverse_dir    = reverse_dir_q;
	assign drive_volts    = drive_volts_q;
	assign measured_speed = measured_speed_q;

	// A nonzero duty needs a nonzero drive voltage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pwm_duty_q != 8'd0) |-> (drive_volts_q != 16'sd0))
		else $error("duty without drive voltage");

	// The reported speed is always a plausible one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (measured_speed_q <= 16'sd8192 && measured_speed_q >= -16'sd8192))
		else $error("measured speed out of range");

	// An accepted beat keeps the block busy on the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// The magnitude gate keeps the integral bounded.
	assert property (@(posedge clk) disable iff (!arst_n)
		(error_integral_q <= 32'sd5767168 && error_integral_q >= -32'sd5767168))
		else $error("integral escaped its bound");

endmodule
